[sv/masked_nearest_neighbour_lookup_core_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the nearest neighbour lookup core
// Concurrent checks clocked by clk_i; empty when building for synthesis.
// ----------------------------------------------------------------------------
`ifndef MASKED_NEAREST_NEIGHBOUR_LOOKUP_CORE_MACROS_SVH
`define MASKED_NEAREST_NEIGHBOUR_LOOKUP_CORE_MACROS_SVH

`ifndef SYNTHESIS
// checked outside reset only
`define MNNL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// checked during reset too
`define MNNL_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define MNNL_ASSERT(lbl, prop, msg)
`define MNNL_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

[sv/mnnl_pkg.sv]
// ----------------------------------------------------------------------------
// mnnl_pkg
// Shared types and constants of the nearest neighbour lookup core.
// ----------------------------------------------------------------------------
package mnnl_pkg;

  localparam int OP_W       = 2;
  localparam int ENT_IDX_W  = 10;
  localparam int FEAT_IDX_W = 4;
  localparam int FEAT_W     = 16;
  localparam int REW_W      = 32;

  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_ENT_W  = 11;
  localparam int CFG_FEAT_W = 5;

  localparam logic [CFG_IDX_W-1:0] CFG_ENTRIES  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_FEATURES = CFG_IDX_W'(1);

  localparam logic [CFG_ENT_W-1:0]  ENTRIES_RST  = CFG_ENT_W'(1024);
  localparam logic [CFG_FEAT_W-1:0] FEATURES_RST = CFG_FEAT_W'(16);

  typedef enum logic [OP_W-1:0] {
    OP_WR_FEAT = 2'd0,
    OP_WR_REW  = 2'd1,
    OP_QUERY   = 2'd2,
    OP_NONE    = 2'd3
  } op_e;

  typedef struct packed {
    logic clr;
    logic wr_feat;
    logic wr_rew;
    logic wr_query;
    logic start;
    logic issue;
    logic first;
    logic last;
    logic load;
  } cmd_t;

endpackage

[sv/mnnl_dp.sv]
// ----------------------------------------------------------------------------
// mnnl_dp
// Reference and query memories, squared distance pipeline, best tracker
// and result register.
// ----------------------------------------------------------------------------
module mnnl_dp import mnnl_pkg::*; #(
  parameter int MAX_ENTRIES  = 1024,
  parameter int MAX_FEATURES = 16,
  parameter int EntW         = 10,
  parameter int FeatW        = 4
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  cmd_t                     cmd_i,
  input  logic [EntW-1:0]          ent_i,
  input  logic [FeatW-1:0]         feat_i,
  input  logic signed [FEAT_W-1:0] feature_value_i,
  input  logic signed [REW_W-1:0]  reward_in_i,
  input  logic                     reward_valid_i,
  output logic                     busy_o,
  output logic signed [REW_W-1:0]  reward_out_o,
  output logic [ENT_IDX_W-1:0]     best_entry_o,
  output logic                     found_o
);

  localparam int FeatDepth = 2 ** FeatW;
  localparam int AccW      = 32 + $clog2(MAX_FEATURES);

  logic [FEAT_W-1:0] fmem [MAX_ENTRIES * FeatDepth];
  logic [REW_W:0]    rmem [MAX_ENTRIES];
  logic [FEAT_W-1:0] qmem [FeatDepth];

  logic [FEAT_W-1:0] feat_rd_q, qry_rd_q;
  logic [REW_W:0]    rew_rd_q;

  logic            s1_v_q, s1_first_q, s1_last_q;
  logic [EntW-1:0] s1_ent_q;

  logic             s2_v_q, s2_first_q, s2_last_q, s2_ok_q;
  logic [EntW-1:0]  s2_ent_q;
  logic [REW_W-1:0] s2_rew_q;
  logic [31:0]      s2_sq_q;

  logic             s3_v_q, s3_last_q, s3_ok_q;
  logic [EntW-1:0]  s3_ent_q;
  logic [REW_W-1:0] s3_rew_q;
  logic [AccW-1:0]  acc_q;

  logic             any_q;
  logic [AccW-1:0]  best_d_q;
  logic [EntW-1:0]  best_ent_q;
  logic [REW_W-1:0] best_rew_q;

  logic [REW_W-1:0]     reward_out_q;
  logic [ENT_IDX_W-1:0] best_entry_q;
  logic                 found_q;

  logic [EntW+FeatW-1:0] faddr;
  logic signed [16:0]    diff;
  logic signed [33:0]    prod;
  logic                  better;

  assign faddr = {ent_i, feat_i};

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_feat) begin
      fmem[faddr] <= feature_value_i;
    end
    if (cmd_i.issue) begin
      feat_rd_q <= fmem[faddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.clr) begin
      rmem[ent_i] <= '0;
    end else if (cmd_i.wr_rew) begin
      rmem[ent_i] <= {reward_valid_i, reward_in_i};
    end
    if (cmd_i.issue) begin
      rew_rd_q <= rmem[ent_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_query) begin
      qmem[feat_i] <= feature_value_i;
    end
    if (cmd_i.issue) begin
      qry_rd_q <= qmem[feat_i];
    end
  end

  assign diff = $signed({qry_rd_q[FEAT_W-1], qry_rd_q}) -
                $signed({feat_rd_q[FEAT_W-1], feat_rd_q});
  assign prod = diff * diff;
  assign better = !any_q || (acc_q < best_d_q);

  // valid bits of the pipeline
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
      any_q  <= 1'b0;
    end else begin
      s1_v_q <= cmd_i.issue;
      s2_v_q <= s1_v_q;
      s3_v_q <= s2_v_q;
      if (cmd_i.start) begin
        any_q <= 1'b0;
      end else if (s3_v_q && s3_last_q && s3_ok_q) begin
        any_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    s1_first_q <= cmd_i.first;
    s1_last_q  <= cmd_i.last;
    s1_ent_q   <= ent_i;

    s2_first_q <= s1_first_q;
    s2_last_q  <= s1_last_q;
    s2_ent_q   <= s1_ent_q;
    s2_ok_q    <= rew_rd_q[REW_W];
    s2_rew_q   <= rew_rd_q[REW_W-1:0];
    s2_sq_q    <= prod[31:0];

    s3_last_q <= s2_last_q;
    s3_ent_q  <= s2_ent_q;
    s3_ok_q   <= s2_ok_q;
    s3_rew_q  <= s2_rew_q;
    if (s2_v_q) begin
      acc_q <= s2_first_q ? AccW'(s2_sq_q) : acc_q + AccW'(s2_sq_q);
    end

    if (s3_v_q && s3_last_q && s3_ok_q && better) begin
      best_d_q   <= acc_q;
      best_ent_q <= s3_ent_q;
      best_rew_q <= s3_rew_q;
    end

    if (cmd_i.load) begin
      reward_out_q <= any_q ? best_rew_q : '0;
      best_entry_q <= any_q ? ENT_IDX_W'(best_ent_q) : '0;
      found_q      <= any_q;
    end
  end

  assign busy_o       = s1_v_q | s2_v_q | s3_v_q;
  assign reward_out_o = reward_out_q;
  assign best_entry_o = best_entry_q;
  assign found_o      = found_q;

endmodule

[sv/mnnl_ctrl.sv]
// ----------------------------------------------------------------------------
// mnnl_ctrl
// Sequencer: configuration registers, memory clear after reset, input
// decode, entry by feature scan and result handshake.
// ----------------------------------------------------------------------------
`include "masked_nearest_neighbour_lookup_core_macros.svh"

module mnnl_ctrl import mnnl_pkg::*; #(
  parameter int MAX_ENTRIES  = 1024,
  parameter int MAX_FEATURES = 16,
  parameter int EntW         = 10,
  parameter int FeatW        = 4
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [OP_W-1:0]       op_i,
  input  logic [ENT_IDX_W-1:0]  entry_index_i,
  input  logic [FEAT_IDX_W-1:0] feature_index_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  input  logic                  busy_i,
  output cmd_t                  cmd_o,
  output logic [EntW-1:0]       ent_o,
  output logic [FeatW-1:0]      feat_o
);

  localparam int CntW = (EntW + 1 > CFG_ENT_W) ? EntW + 1 : CFG_ENT_W;
  localparam int FcW  = (FeatW + 1 > CFG_FEAT_W) ? FeatW + 1 : CFG_FEAT_W;
  localparam int QW   = (FeatW > FEAT_IDX_W) ? FeatW : FEAT_IDX_W;
  localparam logic [EntW-1:0]  EntLast  = EntW'(MAX_ENTRIES - 1);
  localparam logic [FeatW-1:0] FeatLast = FeatW'(MAX_FEATURES - 1);

  typedef enum logic [3:0] {
    ST_CLEAR  = 4'b0001,
    ST_IDLE   = 4'b0010,
    ST_SEARCH = 4'b0100,
    ST_DRAIN  = 4'b1000
  } state_e;

  state_e state_q, state_d;
  logic [EntW-1:0]       e_q, e_d;
  logic [FeatW-1:0]      f_q, f_d;
  logic                  out_valid_q, out_valid_d;
  logic [CFG_ENT_W-1:0]  entries_q;
  logic [CFG_FEAT_W-1:0] features_q;

  logic [CntW-1:0]  ent_cnt;
  logic [FcW-1:0]   feat_cnt;
  logic [EntW-1:0]  ne_last;
  logic [FeatW-1:0] nf_last;
  logic             is_final, ent_ok, feat_ok, in_ready;
  op_e              op;
  cmd_t             cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entries_q  <= ENTRIES_RST;
      features_q <= FEATURES_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_ENTRIES:  entries_q  <= cfg_data_i[CFG_ENT_W-1:0];
        CFG_FEATURES: features_q <= cfg_data_i[CFG_FEAT_W-1:0];
        default: ;
      endcase
    end
  end

  // effective counts saturate to 1..max
  always_comb begin
    ent_cnt  = CntW'(entries_q);
    feat_cnt = FcW'(features_q);
    if (ent_cnt == '0) begin
      ne_last = '0;
    end else if (ent_cnt > CntW'(MAX_ENTRIES)) begin
      ne_last = EntLast;
    end else begin
      ne_last = EntW'(ent_cnt - 1'b1);
    end
    if (feat_cnt == '0) begin
      nf_last = '0;
    end else if (feat_cnt > FcW'(MAX_FEATURES)) begin
      nf_last = FeatLast;
    end else begin
      nf_last = FeatW'(feat_cnt - 1'b1);
    end
  end

  assign op       = op_e'(op_i);
  assign ent_ok   = CntW'(entry_index_i) < CntW'(MAX_ENTRIES);
  assign feat_ok  = FcW'(feature_index_i) < FcW'(MAX_FEATURES);
  assign is_final = (op == OP_QUERY) && (QW'(feature_index_i) == QW'(nf_last));

  always_comb begin
    cmd         = '0;
    state_d     = state_q;
    e_d         = e_q;
    f_d         = f_q;
    in_ready    = 1'b0;
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      ST_CLEAR: begin
        cmd.clr = 1'b1;
        e_d     = EntW'(e_q + 1'b1);
        if (e_q == EntLast) begin
          e_d     = '0;
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = !(out_valid_q && is_final);
        if (in_valid_i && in_ready) begin
          unique case (op)
            OP_WR_FEAT: cmd.wr_feat = ent_ok && feat_ok;
            OP_WR_REW:  cmd.wr_rew  = ent_ok;
            OP_QUERY: begin
              cmd.wr_query = feat_ok;
              if (is_final) begin
                cmd.start = 1'b1;
                e_d       = '0;
                f_d       = '0;
                state_d   = ST_SEARCH;
              end
            end
            default: ;
          endcase
        end
      end
      ST_SEARCH: begin
        cmd.issue = 1'b1;
        cmd.first = (f_q == '0);
        cmd.last  = (f_q == nf_last);
        if (f_q == nf_last) begin
          f_d = '0;
          if (e_q == ne_last) begin
            state_d = ST_DRAIN;
          end else begin
            e_d = EntW'(e_q + 1'b1);
          end
        end else begin
          f_d = FeatW'(f_q + 1'b1);
        end
      end
      ST_DRAIN: begin
        if (!busy_i) begin
          cmd.load    = 1'b1;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      e_q         <= '0;
      f_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      e_q         <= e_d;
      f_q         <= f_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = in_ready;
  assign out_valid_o = out_valid_q;
  assign cmd_o       = cmd;
  assign ent_o       = (state_q == ST_IDLE) ? EntW'(entry_index_i) : e_q;
  assign feat_o      = (state_q == ST_IDLE) ? FeatW'(feature_index_i) : f_q;

  `MNNL_ASSERT(a_load_after_drain, cmd.load |-> !busy_i, "result loaded with pipeline busy")
  `MNNL_ASSERT(a_no_start_pending, cmd.start |-> !out_valid_q, "search started over pending result")
  `MNNL_ASSERT(a_rose_from_drain, $rose(out_valid_q) |-> $past(state_q == ST_DRAIN), "result without search")
  `MNNL_ASSERT(a_scan_in_range, cmd.issue |-> (e_q <= ne_last) && (f_q <= nf_last), "scan out of range")
  `MNNL_ASSERT_ALWAYS(a_no_write_in_scan, (cmd.issue || cmd.clr) |-> !(cmd.wr_feat || cmd.wr_rew || cmd.wr_query), "write during scan")

endmodule

[sv/masked_nearest_neighbour_lookup_core.sv]
// ----------------------------------------------------------------------------
// masked_nearest_neighbour_lookup_core
// Masked one-nearest-neighbour lookup by squared Euclidean distance.
// ----------------------------------------------------------------------------
// Reference writes and non-final query elements are taken while idle. The
// query element at the last feature position starts a scan with one
// multiply-accumulate per cycle over entries_in_use * features_in_use
// feature pairs (effective counts), followed by the pipeline drain and the
// result load; the single feature memory read port sets the scan rate.
// During the scan no item is taken; writes are still taken while a result
// waits, but a new final query element waits until the result transfer.
// After reset a clearing pass over the reward memory runs before the first
// item is taken; configuration writes are taken at all times.
module masked_nearest_neighbour_lookup_core import mnnl_pkg::*; #(
  parameter int MAX_ENTRIES  = 1024,
  parameter int MAX_FEATURES = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [CFG_DATA_W-1:0]    cfg_data_i,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [OP_W-1:0]          op_i,
  input  logic [ENT_IDX_W-1:0]     entry_index_i,
  input  logic [FEAT_IDX_W-1:0]    feature_index_i,
  input  logic signed [FEAT_W-1:0] feature_value_i,
  input  logic signed [REW_W-1:0]  reward_in_i,
  input  logic                     reward_valid_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic signed [REW_W-1:0]  reward_out_o,
  output logic [ENT_IDX_W-1:0]     best_entry_o,
  output logic                     found_o
);

  localparam int EntW  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int FeatW = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;

  cmd_t             cmd;
  logic             busy;
  logic [EntW-1:0]  ent;
  logic [FeatW-1:0] feat;

  assign cfg_ready_o = 1'b1;

  mnnl_ctrl #(
    .MAX_ENTRIES  (MAX_ENTRIES),
    .MAX_FEATURES (MAX_FEATURES),
    .EntW         (EntW),
    .FeatW        (FeatW)
  ) u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .op_i            (op_i),
    .entry_index_i   (entry_index_i),
    .feature_index_i (feature_index_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .busy_i          (busy),
    .cmd_o           (cmd),
    .ent_o           (ent),
    .feat_o          (feat)
  );

  mnnl_dp #(
    .MAX_ENTRIES  (MAX_ENTRIES),
    .MAX_FEATURES (MAX_FEATURES),
    .EntW         (EntW),
    .FeatW        (FeatW)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .ent_i           (ent),
    .feat_i          (feat),
    .feature_value_i (feature_value_i),
    .reward_in_i     (reward_in_i),
    .reward_valid_i  (reward_valid_i),
    .busy_o          (busy),
    .reward_out_o    (reward_out_o),
    .best_entry_o    (best_entry_o),
    .found_o         (found_o)
  );

endmodule

[tb/tb_lookup_checker.sv]
// ----------------------------------------------------------------------------
// tb_lookup_checker
// Watches the configuration, item and result channels of the lookup core.
// It keeps its own copy of the reference tables, the query vector and the
// count registers, works out the nearest valid entry whenever a final query
// element is taken, and compares every result transfer with the oldest
// lookup still due. It reports mismatches and the number of lookups due.
// ----------------------------------------------------------------------------
module tb_lookup_checker import mnnl_pkg::*; #(
  parameter int MAX_ENTRIES  = 1024,
  parameter int MAX_FEATURES = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_valid_i,
  input  logic                     cfg_ready_i,
  input  logic [CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [CFG_DATA_W-1:0]    cfg_data_i,
  input  logic                     in_valid_i,
  input  logic                     in_ready_i,
  input  logic [OP_W-1:0]          op_i,
  input  logic [ENT_IDX_W-1:0]     entry_index_i,
  input  logic [FEAT_IDX_W-1:0]    feature_index_i,
  input  logic signed [FEAT_W-1:0] feature_value_i,
  input  logic signed [REW_W-1:0]  reward_in_i,
  input  logic                     reward_valid_i,
  input  logic                     out_valid_i,
  input  logic                     out_ready_i,
  input  logic signed [REW_W-1:0]  reward_out_i,
  input  logic [ENT_IDX_W-1:0]     best_entry_i,
  input  logic                     found_i,
  output int                       mismatch_count_o,
  output int                       lookups_due_o
);

  typedef struct packed {
    logic signed [REW_W-1:0] reward;
    logic [ENT_IDX_W-1:0]    entry;
    logic                    found;
  } lookup_t;

  logic signed [FEAT_W-1:0] stored_feat [MAX_ENTRIES*MAX_FEATURES];
  logic signed [REW_W-1:0]  stored_reward [MAX_ENTRIES];
  logic                     reward_live [MAX_ENTRIES];
  logic signed [FEAT_W-1:0] query_elem [MAX_FEATURES];
  logic [CFG_ENT_W-1:0]     entries_reg;
  logic [CFG_FEAT_W-1:0]    features_reg;
  lookup_t                  lookups_due [$];

  function automatic int eff_count(int v, int maxv);
    if (v == 0) return 1;
    return (v > maxv) ? maxv : v;
  endfunction

  function automatic lookup_t nearest_valid_entry();
    int                 ne;
    int                 nf;
    bit                 any;
    longint unsigned    best_d;
    longint unsigned    d;
    longint             diff;
    int                 best_i;
    lookup_t            r;
    ne     = eff_count(int'(entries_reg), MAX_ENTRIES);
    nf     = eff_count(int'(features_reg), MAX_FEATURES);
    any    = 1'b0;
    best_d = '0;
    best_i = 0;
    for (int e = 0; e < ne; e++) begin
      if (!reward_live[e]) continue;
      d = '0;
      for (int f = 0; f < nf; f++) begin
        diff = longint'(query_elem[f]) - longint'(stored_feat[e*MAX_FEATURES + f]);
        d += longint'(diff * diff);
      end
      if (!any || d < best_d) begin
        any    = 1'b1;
        best_d = d;
        best_i = e;
      end
    end
    r.found  = any;
    r.reward = any ? stored_reward[best_i] : '0;
    r.entry  = any ? ENT_IDX_W'(best_i) : '0;
    return r;
  endfunction

  task automatic note_mismatch(string msg);
    mismatch_count_o++;
    if (mismatch_count_o <= 10) $display("%0t: %s", $realtime, msg);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    lookup_t got;
    lookup_t want;
    int      nf;
    if (!rst_ni) begin
      entries_reg  = ENTRIES_RST;
      features_reg = FEATURES_RST;
      for (int i = 0; i < MAX_ENTRIES; i++) reward_live[i] = 1'b0;
      lookups_due.delete();
    end else begin
      // results first: a result never belongs to an item taken on the same edge
      if (out_valid_i && out_ready_i) begin
        got = {reward_out_i, best_entry_i, found_i};
        if (lookups_due.size() == 0) begin
          note_mismatch($sformatf("unexpected lookup result: reward %h entry %0d found %0b",
                                  got.reward, got.entry, got.found));
        end else begin
          want = lookups_due.pop_front();
          if (got.reward !== want.reward || got.entry !== want.entry ||
              got.found !== want.found) begin
            note_mismatch($sformatf(
              "lookup mismatch: expected reward %h entry %0d found %0b, got %h %0d %0b",
              want.reward, want.entry, want.found, got.reward, got.entry, got.found));
          end
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_ENTRIES:  entries_reg  = cfg_data_i[CFG_ENT_W-1:0];
          CFG_FEATURES: features_reg = cfg_data_i[CFG_FEAT_W-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) begin
        case (op_e'(op_i))
          OP_WR_FEAT: begin
            if (int'(entry_index_i) < MAX_ENTRIES && int'(feature_index_i) < MAX_FEATURES)
              stored_feat[int'(entry_index_i)*MAX_FEATURES + int'(feature_index_i)] =
                feature_value_i;
          end
          OP_WR_REW: begin
            if (int'(entry_index_i) < MAX_ENTRIES) begin
              stored_reward[entry_index_i] = reward_in_i;
              reward_live[entry_index_i]   = reward_valid_i;
            end
          end
          OP_QUERY: begin
            nf = eff_count(int'(features_reg), MAX_FEATURES);
            if (int'(feature_index_i) < MAX_FEATURES)
              query_elem[feature_index_i] = feature_value_i;
            if (int'(feature_index_i) == nf - 1)
              lookups_due = {lookups_due, nearest_valid_entry()};
          end
          default: ;
        endcase
      end
    end
    lookups_due_o = lookups_due.size();
  end

endmodule

[tb/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the masked nearest neighbour lookup core. A short directed
// run covers empty tables, ties, masked exact matches and extreme values;
// then phases with different count settings and idling patterns send
// random reference writes followed by full queries. The checker beside
// the core predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;
  import mnnl_pkg::*;

  localparam int MAX_ENTRIES    = 1024;
  localparam int MAX_FEATURES   = 16;
  localparam int WATCHDOG_LIMIT = 200000;
  localparam int DRAIN_CYCLES   = 20;
  localparam int HOLD_CYCLES    = 400;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LAST = '1;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic [CFG_IDX_W-1:0]     cfg_index = CFG_ENTRIES;
  logic [CFG_DATA_W-1:0]    cfg_data = '0;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic [OP_W-1:0]          op = OP_NONE;
  logic [ENT_IDX_W-1:0]     entry_index = '0;
  logic [FEAT_IDX_W-1:0]    feature_index = '0;
  logic signed [FEAT_W-1:0] feature_value = '0;
  logic signed [REW_W-1:0]  reward_in = '0;
  logic                     reward_valid = 1'b0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic signed [REW_W-1:0]  reward_out;
  logic [ENT_IDX_W-1:0]     best_entry;
  logic                     found;
  int                       errors;
  int                       pending;

  int tx_idle_pct = 0;
  int rx_stall_pct = 0;
  int hold_ticket = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int items_sent = 0;
  int n_ent = MAX_ENTRIES;
  int n_feat = MAX_FEATURES;
  int quiet = 0;

  // which table cells and query elements hold a written value
  bit [MAX_FEATURES-1:0] feat_known [MAX_ENTRIES];
  bit                    ent_ok [MAX_ENTRIES];
  bit [MAX_FEATURES-1:0] qry_known;

  masked_nearest_neighbour_lookup_core #(
    .MAX_ENTRIES  (MAX_ENTRIES),
    .MAX_FEATURES (MAX_FEATURES)
  ) dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready),
    .op_i            (op),
    .entry_index_i   (entry_index),
    .feature_index_i (feature_index),
    .feature_value_i (feature_value),
    .reward_in_i     (reward_in),
    .reward_valid_i  (reward_valid),
    .out_valid_o     (out_valid),
    .out_ready_i     (out_ready),
    .reward_out_o    (reward_out),
    .best_entry_o    (best_entry),
    .found_o         (found)
  );

  tb_lookup_checker #(
    .MAX_ENTRIES  (MAX_ENTRIES),
    .MAX_FEATURES (MAX_FEATURES)
  ) lookup_check (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_i      (cfg_ready),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data),
    .in_valid_i       (in_valid),
    .in_ready_i       (in_ready),
    .op_i             (op),
    .entry_index_i    (entry_index),
    .feature_index_i  (feature_index),
    .feature_value_i  (feature_value),
    .reward_in_i      (reward_in),
    .reward_valid_i   (reward_valid),
    .out_valid_i      (out_valid),
    .out_ready_i      (out_ready),
    .reward_out_i     (reward_out),
    .best_entry_i     (best_entry),
    .found_i          (found),
    .mismatch_count_o (errors),
    .lookups_due_o    (pending)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // result side: random stalls plus the occasional long hold-off
  always @(negedge clk) begin
    if (hold_ticket != hold_seen) begin
      hold_seen = hold_ticket;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= (int'($urandom_range(0, 99)) >= rx_stall_pct);
    end
  end

  initial begin
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("TB_ERROR");
    $finish;
  end

  // called at a falling edge; returns at the falling edge after the transfer
  // with valid still high, so a following item goes out without a gap
  task automatic send_item(op_e o, int e, int f, logic [FEAT_W-1:0] fv,
                           logic [REW_W-1:0] rw, bit rv);
    if (int'($urandom_range(0, 99)) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
      while (int'($urandom_range(0, 99)) < tx_idle_pct) @(negedge clk);
    end
    in_valid      <= 1'b1;
    op            <= o;
    entry_index   <= ENT_IDX_W'(e);
    feature_index <= FEAT_IDX_W'(f);
    feature_value <= fv;
    reward_in     <= rw;
    reward_valid  <= rv;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    case (o)
      OP_WR_FEAT: feat_known[e][f] = 1'b1;
      OP_WR_REW:  ent_ok[e] = rv;
      OP_QUERY:   qry_known[f] = 1'b1;
      default: ;
    endcase
    if (o != OP_NONE) items_sent++;
  endtask

  task automatic put_feature(int e, int f, logic [FEAT_W-1:0] v);
    send_item(OP_WR_FEAT, e, f, v, REW_W'($urandom), 1'($urandom));
  endtask

  task automatic put_reward(int e, logic [REW_W-1:0] r, bit ok);
    send_item(OP_WR_REW, e, int'($urandom_range(0, MAX_FEATURES-1)), FEAT_W'($urandom), r, ok);
  endtask

  task automatic put_query(int f, logic [FEAT_W-1:0] v);
    send_item(OP_QUERY, int'($urandom_range(0, MAX_ENTRIES-1)), f, v, REW_W'($urandom),
              1'($urandom));
  endtask

  function automatic logic [FEAT_W-1:0] pick_feature();
    case ($urandom_range(0, 7))
      0: begin
        case ($urandom_range(0, 3))
          0:       return 16'h8000;
          1:       return 16'h7fff;
          2:       return 16'h0000;
          default: return 16'hffff;
        endcase
      end
      // a few values close together make equal distances likely
      1, 2:    return FEAT_W'($urandom_range(0, 6)) - FEAT_W'(3);
      default: return FEAT_W'($urandom);
    endcase
  endfunction

  function automatic int pick_entry();
    if ($urandom_range(0, 15) == 0) return int'($urandom_range(0, MAX_ENTRIES-1));
    return int'($urandom_range(0, (n_ent < MAX_ENTRIES) ? n_ent : MAX_ENTRIES-1));
  endfunction

  // stop offering items and wait until the core has delivered everything
  task automatic settle();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // unused upper data bits carry random values
  task automatic set_config(int ent_v, int feat_v);
    write_reg(CFG_ENTRIES, {(CFG_DATA_W-CFG_ENT_W)'($urandom), CFG_ENT_W'(ent_v)});
    write_reg(CFG_FEATURES, {(CFG_DATA_W-CFG_FEAT_W)'($urandom), CFG_FEAT_W'(feat_v)});
    n_ent  = (ent_v == 0) ? 1 : ((ent_v > MAX_ENTRIES) ? MAX_ENTRIES : ent_v);
    n_feat = (feat_v == 0) ? 1 : ((feat_v > MAX_FEATURES) ? MAX_FEATURES : feat_v);
  endtask

  // reference writes, maybe a no-op or spare query item, the cells a search reads, one full query
  task automatic run_round();
    int k;
    int e;
    int f;
    k = int'($urandom_range(0, 6));
    repeat (k) begin
      e = pick_entry();
      if ($urandom_range(0, 1) == 1)
        put_feature(e, int'($urandom_range(0, MAX_FEATURES-1)), pick_feature());
      else
        put_reward(e, REW_W'($urandom), $urandom_range(0, 3) != 0);
    end
    if ($urandom_range(0, 7) == 0) begin
      if ($urandom_range(0, 1) == 0 || n_feat == MAX_FEATURES)
        send_item(OP_NONE, int'($urandom_range(0, MAX_ENTRIES-1)),
                  int'($urandom_range(0, MAX_FEATURES-1)), FEAT_W'($urandom),
                  REW_W'($urandom), 1'($urandom));
      else
        put_query(int'($urandom_range(n_feat, MAX_FEATURES-1)), pick_feature());
    end
    for (e = 0; e < n_ent; e++) begin
      if (ent_ok[e]) begin
        for (f = 0; f < n_feat; f++)
          if (!feat_known[e][f]) put_feature(e, f, pick_feature());
      end
    end
    for (f = 0; f < n_feat - 1; f++)
      if (!qry_known[f] || $urandom_range(0, 1) == 1) put_query(f, pick_feature());
    put_query(n_feat - 1, pick_feature());
  endtask

  initial begin
    int ph;
    int ent_v;
    int feat_v;
    int quota;
    int phase_end;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    set_config(4, 2);
    send_item(OP_NONE, int'($urandom_range(0, MAX_ENTRIES-1)),
              int'($urandom_range(0, MAX_FEATURES-1)), FEAT_W'($urandom),
              REW_W'($urandom), 1'b1);
    // nothing valid yet
    put_query(0, 16'h8000);
    put_query(1, 16'h7fff);
    // two entries at the largest distance from the query, lowest index wins
    put_feature(0, 0, 16'h7fff);
    put_feature(0, 1, 16'h8000);
    put_reward(0, 32'h7fffffff, 1'b1);
    put_feature(1, 0, 16'h7fff);
    put_feature(1, 1, 16'h8000);
    put_reward(1, 32'h80000000, 1'b1);
    put_query(1, 16'h7fff);
    // exact match is masked, the next closest entry wins
    put_feature(2, 0, 16'h8000);
    put_feature(2, 1, 16'h7fff);
    put_reward(2, 32'h00000000, 1'b0);
    put_feature(3, 0, 16'h8001);
    put_feature(3, 1, 16'h7fff);
    put_reward(3, 32'hffffffff, 1'b1);
    put_reward(MAX_ENTRIES-1, 32'h5a5a5a5a, 1'b1);
    put_query(MAX_FEATURES-1, 16'h1234);
    put_query(1, 16'h7fff);

    for (ph = 0; ph < 8; ph++) begin
      settle();
      case (ph)
        0:       begin ent_v = MAX_ENTRIES; feat_v = MAX_FEATURES; quota = 20; end
        1:       begin ent_v = 0;           feat_v = 0;            quota = 70; end
        2:       begin ent_v = 16;          feat_v = 4;            quota = 70; end
        3:       begin ent_v = 2047;        feat_v = 1;            quota = 70; end
        4:       begin ent_v = 8;           feat_v = 31;           quota = 30; end
        5:       begin ent_v = 5;           feat_v = 2;            quota = 70; end
        6:       begin ent_v = 32;          feat_v = 3;            quota = 80; end
        default: begin ent_v = 12;          feat_v = 5;            quota = 70; end
      endcase
      case (ph % 4)
        0:       begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1:       begin tx_idle_pct = 85; rx_stall_pct = 0;  end
        2:       begin tx_idle_pct = 0;  rx_stall_pct = 85; end
        default: begin tx_idle_pct = 24; rx_stall_pct = 24; end
      endcase
      if (ph == 6) begin
        write_reg(CFG_SPARE_LAST, CFG_DATA_W'($urandom));
        write_reg(CFG_FEATURES + CFG_IDX_W'($urandom_range(1, 13)), CFG_DATA_W'($urandom));
      end
      set_config(ent_v, feat_v);
      // one count each: every query element at index zero ends a lookup; a held result stalls them
      if (ph == 1) hold_ticket++;
      phase_end = items_sent + quota;
      while (items_sent < phase_end) run_round();
    end
    settle();

    if (errors == 0 && pending == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule

[files.f]
+incdir+sv
sv/mnnl_pkg.sv
sv/mnnl_dp.sv
sv/mnnl_ctrl.sv
sv/masked_nearest_neighbour_lookup_core.sv
tb/tb_lookup_checker.sv
tb/tb_top.sv
